// ----- rtl/external_interrupt_controller_unit_defines.svh -----
// Assertion macros shared by the RTL of the external interrupt controller.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef EXTERNAL_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define EXTERNAL_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// The condition must never hold while out of reset.
`define EIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define EIC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/eic_pkg.sv -----
package eic_pkg;

  localparam int LINE_COUNT  = 23;
  localparam int PIN_COUNT   = 16;
  localparam int INT_COUNT   = LINE_COUNT - PIN_COUNT;
  localparam int GROUP_COUNT = 7;
  localparam int LINE_W      = 5;
  localparam int CFG_W       = LINE_COUNT;
  localparam int CFG_IDX_W   = 3;
  localparam int SEL_W       = 16;
  localparam int CODE_W      = 4;
  localparam int CODES_PER_REG = SEL_W / CODE_W;
  localparam int SEL_REGS    = PIN_COUNT / CODES_PER_REG;

  localparam logic [LINE_COUNT-1:0] INVALID_LINES = 23'h18_0000;
  localparam logic [LINE_COUNT-1:0] VALID_LINES   = ~INVALID_LINES;

  // Ranges of the two shared groups; the top line is the fallback.
  localparam int GRP5_LO = 5;
  localparam int GRP5_HI = 9;
  localparam int GRP6_LO = 10;
  localparam int GRP6_HI = 15;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SOFT  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_ACK   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_RISING   = 3'd1,
    CFG_FALLING  = 3'd2,
    CFG_SEL_0_3  = 3'd3,
    CFG_SEL_4_7  = 3'd4,
    CFG_SEL_8_11 = 3'd5,
    CFG_SEL_12_15 = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    PORT_A = 2'd0,
    PORT_B = 2'd1,
    PORT_C = 2'd2
  } port_code_t;

  localparam logic [2:0] GROUP_FIRST_SHARED = 3'd5;
  localparam logic [2:0] GROUP_LINES_5_9    = 3'd5;
  localparam logic [2:0] GROUP_LINES_10_15  = 3'd6;
  localparam logic [2:0] GROUP_NONE         = 3'd7;

  // Lowest pending line in [lo, hi), or hi when none of them is pending.
  function automatic logic [LINE_W-1:0] lowest_pending(
    input logic [LINE_COUNT-1:0] pend,
    input int lo,
    input int hi
  );
    logic [LINE_W-1:0] pick;
    pick = LINE_W'(hi);
    for (int i = hi - 1; i >= lo; i--) begin
      if (pend[i]) begin
        pick = LINE_W'(i);
      end
    end
    return pick;
  endfunction

endpackage

// ----- rtl/external_interrupt_controller_unit.sv -----
// External interrupt edge controller for 23 lines. Lines 0 to 15 follow pin i
// of port A, B or C as chosen by a 4-bit code per line (codes 3 to 15 read
// low); lines 16 to 22 follow the internal event lines. Lines 19 and 20 do not
// exist: they never become pending and cannot be enabled. Each item carries a
// command: a tick samples the pins and sets pending on the selected rising or
// falling edges, a software trigger sets pending, a clear drops pending for
// the lines in the mask, and an acknowledge clears one line of a group (for
// the shared groups the lowest pending line, or the top line of the group if
// none is pending). Every item yields exactly one result: the pending word
// after the command, the per-group requests, the requests of lines 16 to 22
// and the acknowledged line. The block takes one item in every clock cycle
// while its input is not stalled. An item passes the input register, then
// the result register, and all state is updated as the result register loads.
// A stalled result holds the result register, which then stalls the input
// side only once the input register is full too. Configuration registers
// reset to zero and are written through a plain write port; the user must
// write them only while the block is idle, which the block does not check.
`include "external_interrupt_controller_unit_defines.svh"

module external_interrupt_controller_unit
  import eic_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port.
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // Input channel.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic [LINE_COUNT-1:0]   line_mask,
  input  logic [2:0]              group_index,
  input  logic [PIN_COUNT-1:0]    port_a_pins,
  input  logic [PIN_COUNT-1:0]    port_b_pins,
  input  logic [PIN_COUNT-1:0]    port_c_pins,
  input  logic [INT_COUNT-1:0]    internal_lines,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LINE_COUNT-1:0]   pending_bits,
  output logic [GROUP_COUNT-1:0]  group_requests,
  output logic [INT_COUNT-1:0]    high_line_requests,
  output logic [LINE_W-1:0]       acknowledged_line
);

  // Configuration registers.
  logic [LINE_COUNT-1:0] line_enable;
  logic [LINE_COUNT-1:0] rising_sel;
  logic [LINE_COUNT-1:0] falling_sel;
  logic [SEL_W-1:0]      port_select [SEL_REGS];

  // Controller state.
  logic [LINE_COUNT-1:0] previous_levels;
  logic [LINE_COUNT-1:0] pending;
  logic [LINE_COUNT-1:0] software_requests;

  // Input register.
  logic                   s1_valid;
  mode_t                  s1_mode;
  logic [LINE_COUNT-1:0]  s1_line_mask;
  logic [2:0]             s1_group;
  logic [PIN_COUNT-1:0]   s1_pa;
  logic [PIN_COUNT-1:0]   s1_pb;
  logic [PIN_COUNT-1:0]   s1_pc;
  logic [INT_COUNT-1:0]   s1_int;

  logic out_free;
  logic in_accept;

  // The result register can load when it is empty or being emptied now.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_enable <= '0;
      rising_sel  <= '0;
      falling_sel <= '0;
      for (int r = 0; r < SEL_REGS; r++) begin
        port_select[r] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLE:    line_enable    <= cfg_data & VALID_LINES;
        CFG_RISING:    rising_sel     <= cfg_data;
        CFG_FALLING:   falling_sel    <= cfg_data;
        CFG_SEL_0_3:   port_select[0] <= cfg_data[SEL_W-1:0];
        CFG_SEL_4_7:   port_select[1] <= cfg_data[SEL_W-1:0];
        CFG_SEL_8_11:  port_select[2] <= cfg_data[SEL_W-1:0];
        CFG_SEL_12_15: port_select[3] <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever the item moves on or the stage is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode      <= mode_t'(mode);
      s1_line_mask <= line_mask;
      s1_group     <= group_index;
      s1_pa        <= port_a_pins;
      s1_pb        <= port_b_pins;
      s1_pc        <= port_c_pins;
      s1_int       <= internal_lines;
    end
  end

  // Line levels as seen by a tick.
  logic [LINE_COUNT-1:0] levels;

  always_comb begin
    logic [CODE_W-1:0] code;
    levels = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      code = port_select[i / CODES_PER_REG][(i % CODES_PER_REG) * CODE_W +: CODE_W];
      case (code)
        CODE_W'(PORT_A): levels[i] = s1_pa[i];
        CODE_W'(PORT_B): levels[i] = s1_pb[i];
        CODE_W'(PORT_C): levels[i] = s1_pc[i];
        default:         levels[i] = 1'b0;
      endcase
    end
    levels[LINE_COUNT-1:PIN_COUNT] = s1_int;
  end

  // Next state for the item in the input register.
  logic [LINE_COUNT-1:0] previous_levels_next;
  logic [LINE_COUNT-1:0] pending_next;
  logic [LINE_COUNT-1:0] software_requests_next;
  logic [LINE_W-1:0]     ack_line;
  logic [LINE_COUNT-1:0] requests;

  always_comb begin
    logic [LINE_COUNT-1:0] edges;
    logic [LINE_COUNT-1:0] ack_mask;
    previous_levels_next   = previous_levels;
    pending_next           = pending;
    software_requests_next = software_requests;
    ack_line               = '0;
    edges = (levels & ~previous_levels & rising_sel)
          | (~levels & previous_levels & falling_sel);
    ack_mask = '0;
    case (s1_mode)
      MODE_TICK: begin
        pending_next         = pending | (edges & VALID_LINES);
        previous_levels_next = levels;
      end
      MODE_SOFT: begin
        pending_next           = pending | (s1_line_mask & VALID_LINES);
        software_requests_next = software_requests | (s1_line_mask & VALID_LINES);
      end
      MODE_CLEAR: begin
        pending_next           = pending & ~s1_line_mask;
        software_requests_next = software_requests & ~s1_line_mask;
      end
      MODE_ACK: begin
        if (s1_group != GROUP_NONE) begin
          if (s1_group < GROUP_FIRST_SHARED) begin
            ack_line = LINE_W'(s1_group);
          end else if (s1_group == GROUP_LINES_5_9) begin
            ack_line = lowest_pending(pending, GRP5_LO, GRP5_HI);
          end else begin
            ack_line = lowest_pending(pending, GRP6_LO, GRP6_HI);
          end
          ack_mask = LINE_COUNT'(1) << ack_line;
        end
        pending_next           = pending & ~ack_mask;
        software_requests_next = software_requests & ~ack_mask;
      end
      default: ;
    endcase
    pending_next           = pending_next & VALID_LINES;
    software_requests_next = software_requests_next & VALID_LINES;
    requests               = pending_next & line_enable;
  end

  // State and result register advance together when the item moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      previous_levels   <= '0;
      pending           <= '0;
      software_requests <= '0;
    end else if (out_free) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        previous_levels   <= previous_levels_next;
        pending           <= pending_next;
        software_requests <= software_requests_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      pending_bits       <= pending_next;
      group_requests     <= {|requests[GRP6_HI:GRP6_LO], |requests[GRP5_HI:GRP5_LO],
                             requests[GRP5_LO-1:0]};
      high_line_requests <= requests[LINE_COUNT-1:PIN_COUNT];
      acknowledged_line  <= ack_line;
    end
  end

  `EIC_ASSERT_NEVER(a_no_invalid_pending, pending[19] || pending[20] || software_requests[19] || software_requests[20], "invalid line pending")
  `EIC_ASSERT_IMPLY(a_stall_needs_item, in_stall, s1_valid, "input stalled with empty stage")
  `EIC_ASSERT_IMPLY(a_ack_clears_line, out_valid && (acknowledged_line != '0), !pending_bits[acknowledged_line[3:0]] && (acknowledged_line <= LINE_W'(GRP6_HI)), "acknowledged line still pending")
  `EIC_ASSERT_IMPLY(a_requests_match, out_valid, (high_line_requests & ~pending_bits[LINE_COUNT-1:PIN_COUNT]) == '0, "request without pending")

endmodule

// ----- bench/external_interrupt_controller_unit_tb.sv -----
// Testbench for the external interrupt edge controller.
//
// A scoreboard object keeps its own copy of the controller state (line levels
// seen at the last tick, pending word, software requests) and of every
// configuration register. Each item accepted on the input channel is run
// through that copy, and the result it predicts is queued. Each result
// accepted on the output channel is checked field by field against the
// oldest queued prediction.
//
// The run starts with a directed part at the reset configuration and at one
// hand-picked configuration. It then walks through several random
// configurations, the all-ones and all-zeros extremes among them, and sends
// bursts of random items under each one. The sender often pauses between
// bursts. The receiver's stall pattern changes from window to window, and
// now and then it holds off long enough to fill the block and stall its input.
module external_interrupt_controller_unit_tb
  import eic_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 210;
  localparam int CONFIG_PHASES   = 6;
  localparam int SETTLE_CYCLES   = 4;
  localparam int LONG_HOLD       = 120;
  localparam int STALL_WINDOW    = 48;
  localparam int WATCHDOG_LIMIT  = 2000;

  // Index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct packed {
    mode_t                 mode;
    logic [LINE_COUNT-1:0] line_mask;
    logic [2:0]            group_index;
    logic [PIN_COUNT-1:0]  port_a;
    logic [PIN_COUNT-1:0]  port_b;
    logic [PIN_COUNT-1:0]  port_c;
    logic [INT_COUNT-1:0]  internal;
  } irq_item_t;

  typedef struct packed {
    logic [LINE_COUNT-1:0]  pending;
    logic [GROUP_COUNT-1:0] groups;
    logic [INT_COUNT-1:0]   high_lines;
    logic [LINE_W-1:0]      ack_line;
  } irq_result_t;

  // The scoreboard predicts the result of every accepted item from its own
  // copy of the controller state and compares the results in order.
  class irq_scoreboard;
    logic [LINE_COUNT-1:0] enable_q;
    logic [LINE_COUNT-1:0] rise_sel;
    logic [LINE_COUNT-1:0] fall_sel;
    logic [SEL_W-1:0]      port_sel [SEL_REGS];
    logic [LINE_COUNT-1:0] last_levels;
    logic [LINE_COUNT-1:0] pend;
    logic [LINE_COUNT-1:0] soft_req;
    irq_result_t           expected_q [$];
    int                    errors;

    function new();
      enable_q    = '0;
      rise_sel    = '0;
      fall_sel    = '0;
      last_levels = '0;
      pend        = '0;
      soft_req    = '0;
      errors      = 0;
      foreach (port_sel[n]) port_sel[n] = '0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ENABLE:  enable_q = data & VALID_LINES;
        CFG_RISING:  rise_sel = data;
        CFG_FALLING: fall_sel = data;
        CFG_SEL_0_3, CFG_SEL_4_7, CFG_SEL_8_11, CFG_SEL_12_15:
          port_sel[idx - CFG_SEL_0_3] = data[SEL_W-1:0];
        default: ;
      endcase
    endfunction

    // Line levels as the pins and port codes give them at a tick.
    function logic [LINE_COUNT-1:0] pin_levels(irq_item_t it);
      logic [LINE_COUNT-1:0] levels;
      logic [CODE_W-1:0]     code;
      levels = '0;
      for (int i = 0; i < PIN_COUNT; i++) begin
        code = port_sel[i / CODES_PER_REG][(i % CODES_PER_REG) * CODE_W +: CODE_W];
        if (code == CODE_W'(PORT_A)) levels[i] = it.port_a[i];
        else if (code == CODE_W'(PORT_B)) levels[i] = it.port_b[i];
        else if (code == CODE_W'(PORT_C)) levels[i] = it.port_c[i];
      end
      levels[LINE_COUNT-1:PIN_COUNT] = it.internal;
      return levels;
    endfunction

    function logic [LINE_W-1:0] first_pending(int lo, int hi);
      for (int i = lo; i < hi; i++) begin
        if (pend[i]) return LINE_W'(i);
      end
      return LINE_W'(hi);
    endfunction

    function void note_input(irq_item_t it);
      logic [LINE_COUNT-1:0]  levels;
      logic [LINE_COUNT-1:0]  req;
      logic [LINE_W-1:0]      ack_line;
      irq_result_t            res;
      ack_line = '0;
      case (it.mode)
        MODE_TICK: begin
          levels = pin_levels(it);
          pend |= (((levels & ~last_levels) & rise_sel) |
                   ((~levels & last_levels) & fall_sel)) & VALID_LINES;
          last_levels = levels;
        end
        MODE_SOFT: begin
          soft_req |= it.line_mask & VALID_LINES;
          pend     |= it.line_mask & VALID_LINES;
        end
        MODE_CLEAR: begin
          pend     &= ~it.line_mask;
          soft_req &= ~it.line_mask;
        end
        default: begin
          if (it.group_index != GROUP_NONE) begin
            if (it.group_index < GROUP_FIRST_SHARED) ack_line = LINE_W'(it.group_index);
            else if (it.group_index == GROUP_LINES_5_9) ack_line = first_pending(GRP5_LO, GRP5_HI);
            else ack_line = first_pending(GRP6_LO, GRP6_HI);
            pend[ack_line]     = 1'b0;
            soft_req[ack_line] = 1'b0;
          end
        end
      endcase
      req = pend & enable_q;
      res.pending    = pend;
      res.groups     = {|req[GRP6_HI:GRP6_LO], |req[GRP5_HI:GRP5_LO], req[GRP5_LO-1:0]};
      res.high_lines = req[LINE_COUNT-1:PIN_COUNT];
      res.ack_line   = ack_line;
      expected_q.push_back(res);
    endfunction

    function void check_result(irq_result_t got);
      irq_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no item waiting: pending_bits %h", got.pending);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.pending !== exp_res.pending) begin
        $error("pending_bits: expected %h, actual %h", exp_res.pending, got.pending);
        errors++;
      end
      if (got.groups !== exp_res.groups) begin
        $error("group_requests: expected %h, actual %h", exp_res.groups, got.groups);
        errors++;
      end
      if (got.high_lines !== exp_res.high_lines) begin
        $error("high_line_requests: expected %h, actual %h", exp_res.high_lines, got.high_lines);
        errors++;
      end
      if (got.ack_line !== exp_res.ack_line) begin
        $error("acknowledged_line: expected %0d, actual %0d", exp_res.ack_line, got.ack_line);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             mode;
  logic [LINE_COUNT-1:0]  line_mask;
  logic [2:0]             group_index;
  logic [PIN_COUNT-1:0]   port_a_pins;
  logic [PIN_COUNT-1:0]   port_b_pins;
  logic [PIN_COUNT-1:0]   port_c_pins;
  logic [INT_COUNT-1:0]   internal_lines;
  logic                   out_valid;
  logic                   out_stall;
  logic [LINE_COUNT-1:0]  pending_bits;
  logic [GROUP_COUNT-1:0] group_requests;
  logic [INT_COUNT-1:0]   high_line_requests;
  logic [LINE_W-1:0]      acknowledged_line;

  irq_scoreboard sb;
  bit            hold_request = 1'b0;
  int            idle_cycles  = 0;

  external_interrupt_controller_unit uut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .line_mask          (line_mask),
    .group_index        (group_index),
    .port_a_pins        (port_a_pins),
    .port_b_pins        (port_b_pins),
    .port_c_pins        (port_c_pins),
    .internal_lines     (internal_lines),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pending_bits       (pending_bits),
    .group_requests     (group_requests),
    .high_line_requests (high_line_requests),
    .acknowledged_line  (acknowledged_line)
  );

  always #10 clk = ~clk;

  // Both channels are observed at the rising edge, where every input was
  // driven at the falling edge before it and the registered outputs still
  // hold the values of the closing cycle. The same block keeps the watchdog:
  // it ends the run when no item has moved on either channel for too long.
  always @(posedge clk) begin : channel_monitor
    irq_item_t   seen_item;
    irq_result_t seen_result;
    bit          moved;
    moved = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      seen_item.mode        = mode_t'(mode);
      seen_item.line_mask   = line_mask;
      seen_item.group_index = group_index;
      seen_item.port_a      = port_a_pins;
      seen_item.port_b      = port_b_pins;
      seen_item.port_c      = port_c_pins;
      seen_item.internal    = internal_lines;
      sb.note_input(seen_item);
      moved = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      seen_result.pending    = pending_bits;
      seen_result.groups     = group_requests;
      seen_result.high_lines = high_line_requests;
      seen_result.ack_line   = acknowledged_line;
      sb.check_result(seen_result);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver changes its stall pattern every window. When asked, it
  // holds off for a long stretch so that the result register and then the
  // input register fill up while the sender keeps offering items.
  initial begin : stall_pattern
    stall_style_t style;
    int           period;
    out_stall = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      style  = stall_style_t'($urandom_range(0, 3));
      period = $urandom_range(2, 7);
      for (int c = 0; c < STALL_WINDOW; c++) begin
        @(negedge clk);
        case (style)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:     out_stall = ((c % period) == 0);
        endcase
      end
    end
  end

  // Offers one item and returns at the rising edge that accepts it. The
  // payload and valid are held unchanged for as long as the block stalls.
  task automatic send_item(input irq_item_t it);
    @(negedge clk);
    in_valid       = 1'b1;
    mode           = it.mode;
    line_mask      = it.line_mask;
    group_index    = it.group_index;
    port_a_pins    = it.port_a;
    port_b_pins    = it.port_b;
    port_c_pins    = it.port_c;
    internal_lines = it.internal;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Waits until every predicted result has come back, then lets the block
  // settle so that it is truly idle before the configuration changes.
  task automatic wait_idle();
    pause_sender(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic irq_item_t make_item(mode_t m, logic [LINE_COUNT-1:0] lines,
                                          logic [2:0] grp, logic [PIN_COUNT-1:0] a,
                                          logic [PIN_COUNT-1:0] b, logic [PIN_COUNT-1:0] c,
                                          logic [INT_COUNT-1:0] intl);
    irq_item_t it;
    it.mode        = m;
    it.line_mask   = lines;
    it.group_index = grp;
    it.port_a      = a;
    it.port_b      = b;
    it.port_c      = c;
    it.internal    = intl;
    return it;
  endfunction

  // Half the random items are ticks, so that edges keep arriving between the
  // triggers, clears and acknowledges that drain the pending word.
  function automatic irq_item_t random_item();
    irq_item_t             it;
    int                    pick;
    logic [LINE_COUNT-1:0] lines;
    pick = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0:       lines = '1;
      1:       lines = LINE_COUNT'($urandom & $urandom & $urandom);
      default: lines = LINE_COUNT'($urandom);
    endcase
    it = make_item(pick < 5 ? MODE_TICK : pick < 6 ? MODE_SOFT : pick < 8 ? MODE_CLEAR : MODE_ACK,
                   lines, 3'($urandom_range(0, 7)), PIN_COUNT'($urandom),
                   PIN_COUNT'($urandom), PIN_COUNT'($urandom), INT_COUNT'($urandom));
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Port codes are mostly real ports, with some unused codes mixed in. The
  // bits above the register width are random and must be dropped.
  function automatic logic [CFG_W-1:0] random_select();
    logic [SEL_W-1:0] codes;
    for (int n = 0; n < CODES_PER_REG; n++) begin
      codes[n * CODE_W +: CODE_W] = ($urandom_range(0, 4) != 0) ?
                                    CODE_W'($urandom_range(0, 2)) :
                                    CODE_W'($urandom_range(3, 15));
    end
    return {(CFG_W - SEL_W)'($urandom), codes};
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] data;
    int               sent;
    int               burst;
    sb             = new();
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    mode           = MODE_TICK;
    line_mask      = '0;
    group_index    = '0;
    port_a_pins    = '0;
    port_b_pins    = '0;
    port_c_pins    = '0;
    internal_lines = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // At the reset configuration no edge is selected and nothing is enabled:
    // a tick only records levels, and a software trigger shows up as pending
    // without raising any request.
    send_item(make_item(MODE_TICK, '0, '0, '1, '1, '1, '1));
    send_item(make_item(MODE_SOFT, '1, '0, '0, '0, '0, '0));
    send_item(make_item(MODE_ACK, '0, GROUP_LINES_10_15, '0, '0, '0, '0));
    send_item(make_item(MODE_CLEAR, '1, '0, '0, '0, '0, '0));
    wait_idle();

    // Every existing line enabled on both edges. Lines 0 to 7 rotate through
    // ports A, B, C and an unused code; lines 8 to 11 carry unused code 15 from
    // an all-ones write; lines 12 to 15 follow port A. The write past the last
    // register must have no effect.
    write_config(CFG_UNUSED, '1);
    write_config(CFG_ENABLE, '1);
    write_config(CFG_RISING, '1);
    write_config(CFG_FALLING, '1);
    write_config(CFG_SEL_0_3, CFG_W'(16'h3210));
    write_config(CFG_SEL_4_7, CFG_W'(16'h3210));
    write_config(CFG_SEL_8_11, '1);
    write_config(CFG_SEL_12_15, '0);

    send_item(make_item(MODE_TICK, '0, '0, '0, '0, '0, '0));
    send_item(make_item(MODE_TICK, '0, '0, '1, '1, '1, '1));
    for (int g = 0; g < GRP5_LO; g++) begin
      send_item(make_item(MODE_ACK, '0, 3'(g), '0, '0, '0, '0));
    end
    // Shared groups: lowest pending line first, then the top line once the
    // group has nothing left below it.
    repeat (3) send_item(make_item(MODE_ACK, '0, GROUP_LINES_5_9, '0, '0, '0, '0));
    repeat (2) send_item(make_item(MODE_ACK, '0, GROUP_LINES_10_15, '0, '0, '0, '0));
    send_item(make_item(MODE_ACK, '0, GROUP_NONE, '1, '1, '1, '1));
    send_item(make_item(MODE_SOFT, '1, '0, '1, '0, '1, '0));
    send_item(make_item(MODE_ACK, '0, GROUP_LINES_5_9, '0, '0, '0, '0));
    send_item(make_item(MODE_CLEAR, 23'h15_5555, '0, '0, '0, '0, '0));
    send_item(make_item(MODE_CLEAR, '1, '0, '0, '0, '0, '0));
    send_item(make_item(MODE_ACK, '0, GROUP_LINES_10_15, '0, '0, '0, '0));
    send_item(make_item(MODE_TICK, '0, '0, '1, '0, '1, '0));
    send_item(make_item(MODE_TICK, '0, '0, '0, '0, '0, '0));

    // Random phases: the first writes all ones to every register, the second
    // all zeros, the rest random values.
    for (int p = 0; p < CONFIG_PHASES; p++) begin
      wait_idle();
      for (int r = 0; r < SEL_REGS + CFG_SEL_0_3; r++) begin
        if (p == 0) data = '1;
        else if (p == 1) data = '0;
        else if (r >= CFG_SEL_0_3) data = random_select();
        else data = random_mask();
        write_config(CFG_IDX_W'(r), data);
      end
      if (p % 3 == 0) hold_request = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_item(random_item());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/eic_pkg.sv
rtl/external_interrupt_controller_unit.sv
bench/external_interrupt_controller_unit_tb.sv
